/* design/lpr_pkg.sv */
// Shared types and constants for the line pixel rasterizer.
// Used by lpr_ctrl, lpr_dp and line_pixel_rasterizer; no dependencies.
package lpr_pkg;

  localparam int unsigned CoordW = 4;

  typedef logic [CoordW-1:0] coord_t;

  // Signed step and remainder widths: one and two bits above a coordinate
  localparam int unsigned DeltaW = CoordW + 1;
  localparam int unsigned RemW   = CoordW + 2;

  typedef enum logic [0:0] {
    StIdle,
    StRun
  } lpr_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // take a new line from the input request
    logic advance;  // step to the next pixel
  } lpr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic span_zero;  // incoming line has no pixels
    logic last;       // current pixel closes the run
  } lpr_status_t;

endpackage

/* design/lpr_ctrl.sv */
// Controller for the line pixel rasterizer: idle/run state machine and handshakes.
// Depends on lpr_pkg.
module lpr_ctrl
  import lpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  input  lpr_status_t status_i,
  output lpr_cmd_t    cmd_o
);

  lpr_state_e state_q, state_d;
  logic       take;
  logic       load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    m_tvalid_o = (state_q == StRun);
    take       = m_tvalid_o && m_tready_i;
    // take a new line as soon as the closing pixel leaves
    s_tready_o = (state_q == StIdle) || (take && status_i.last);
    load       = s_tvalid_i && s_tready_o;
    cmd_o.load    = load;
    cmd_o.advance = take && !status_i.last;
    state_d    = state_q;
    case (state_q)
      StIdle: begin
        if (load && !status_i.span_zero) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (take && status_i.last) begin
          state_d = (load && !status_i.span_zero) ? StRun : StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> (state_q == StIdle) || (m_tready_i && status_i.last))
    else $error("input ready while a line is still in progress");

  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !status_i.span_zero) |=> m_tvalid_o)
    else $error("non-empty line produced no pixel");

  a_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && status_i.last && !s_tvalid_i) |=> !m_tvalid_o)
    else $error("pixel presented after the closing pixel");

endmodule

/* design/lpr_dp.sv */
// Datapath for the line pixel rasterizer: endpoint setup and incremental minor-axis stepper.
// Depends on lpr_pkg.
module lpr_dp
  import lpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  coord_t      start_column_i,
  input  coord_t      start_row_i,
  input  coord_t      end_column_i,
  input  coord_t      end_row_i,
  input  lpr_cmd_t    cmd_i,
  output lpr_status_t status_o,
  output coord_t      pixel_column_o,
  output coord_t      pixel_row_o
);

  // setup terms
  coord_t dc, dr, maj_s, maj_e, min_s, min_e, maj_lo, maj_hi, min_lo, min_hi, span;
  logic   col_major, swap;
  logic signed [DeltaW-1:0] delta;

  // run registers
  logic                     col_major_q;
  coord_t                   maj_q, maj_d;
  coord_t                   min_q, min_d;
  coord_t                   span_q;
  coord_t                   cnt_q, cnt_d;
  logic signed [DeltaW-1:0] delta_q;
  logic signed [RemW-1:0]   rem_q, rem_d;
  logic signed [RemW-1:0]   rem_sum, span_s;

  always_comb begin
    dc        = (start_column_i > end_column_i) ? start_column_i - end_column_i
                                                : end_column_i - start_column_i;
    dr        = (start_row_i > end_row_i) ? start_row_i - end_row_i
                                          : end_row_i - start_row_i;
    col_major = dc > dr;
    maj_s     = col_major ? start_column_i : start_row_i;
    maj_e     = col_major ? end_column_i   : end_row_i;
    min_s     = col_major ? start_row_i    : start_column_i;
    min_e     = col_major ? end_row_i      : end_column_i;
    swap      = maj_e < maj_s;
    maj_lo    = swap ? maj_e : maj_s;
    maj_hi    = swap ? maj_s : maj_e;
    min_lo    = swap ? min_e : min_s;
    min_hi    = swap ? min_s : min_e;
    span      = maj_hi - maj_lo;
    delta     = $signed({1'b0, min_hi}) - $signed({1'b0, min_lo});
  end

  // Remainder stays in [0, span); |delta| <= span, so one correction suffices
  always_comb begin
    span_s  = $signed({2'b00, span_q});
    rem_sum = rem_q + {delta_q[DeltaW-1], delta_q};
    rem_d   = rem_sum;
    min_d   = min_q;
    if (rem_sum >= span_s) begin
      rem_d = rem_sum - span_s;
      min_d = min_q + coord_t'(1);
    end else if (rem_sum < 0) begin
      rem_d = rem_sum + span_s;
      min_d = min_q - coord_t'(1);
    end
    maj_d = maj_q + coord_t'(1);
    cnt_d = cnt_q - coord_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_major_q <= 1'b0;
      maj_q       <= '0;
      min_q       <= '0;
      span_q      <= '0;
      cnt_q       <= '0;
      delta_q     <= '0;
      rem_q       <= '0;
    end else if (cmd_i.load) begin
      col_major_q <= col_major;
      maj_q       <= maj_lo;
      min_q       <= min_lo;
      span_q      <= span;
      cnt_q       <= span;
      delta_q     <= delta;
      rem_q       <= $signed({2'b00, span >> 1});
    end else if (cmd_i.advance) begin
      maj_q <= maj_d;
      min_q <= min_d;
      cnt_q <= cnt_d;
      rem_q <= rem_d;
    end
  end

  assign status_o.span_zero = (span == '0);
  assign status_o.last      = (cnt_q == coord_t'(1));
  assign pixel_column_o     = col_major_q ? maj_q : min_q;
  assign pixel_row_o        = col_major_q ? min_q : maj_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q >= 0) && ((span_q == '0) || (rem_q < $signed({2'b00, span_q}))))
    else $error("minor-axis remainder out of range");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= span_q)
    else $error("pixel count exceeds span");

endmodule

/* design/line_pixel_rasterizer.sv */
// Top level of the line pixel rasterizer: stream ports, controller and datapath.
// Depends on lpr_pkg, lpr_ctrl and lpr_dp.
//
// Each input request carries one line as two 4-bit endpoints; the block emits one output
// request per pixel, from the lower end on the major axis up to but excluding the upper
// end, with tlast on the final pixel. A line of span N (1 to 15) yields N pixels, one per
// cycle while the output is ready, and the next line is taken in the cycle its last
// pixel leaves. The rate is set by the single minor-axis stepper, which adds the slope
// to a remainder and corrects it once per pixel. A line whose endpoints coincide on the
// major axis produces no output.
module line_pixel_rasterizer
  import lpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // start_column, start_row, end_column, end_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // pixel_column, pixel_row
  output logic        m_axis_tlast   // last_pixel
);

  lpr_cmd_t    cmd;
  lpr_status_t status;
  coord_t      pixel_column, pixel_row;

  lpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lpr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_column_i (s_axis_tdata[3:0]),
    .start_row_i    (s_axis_tdata[7:4]),
    .end_column_i   (s_axis_tdata[11:8]),
    .end_row_i      (s_axis_tdata[15:12]),
    .cmd_i          (cmd),
    .status_o       (status),
    .pixel_column_o (pixel_column),
    .pixel_row_o    (pixel_row)
  );

  assign m_axis_tdata = {pixel_row, pixel_column};
  assign m_axis_tlast = status.last;

endmodule

/* verif/tb_line_pixel_rasterizer.sv */
// Self-checking testbench for line_pixel_rasterizer: directed lines from a table, then random ones.
// Expected pixels come from a local rasterizer or typed rows; depends on lpr_pkg and the RTL top level.
module tb_line_pixel_rasterizer;
  import lpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomLines = 400;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldAfter   = 60;   // lines accepted before the long hold-off
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned IdlePercent = 28;
  localparam int unsigned CalmFrom    = 2500;
  localparam int unsigned CalmTo      = 4000;
  localparam int unsigned MaxReports  = 10;

  typedef struct {
    coord_t      sc, sr, ec, er;
    bit          typed;      // expectation given by hand as a straight run
    bit          col_major;
    coord_t      first;      // lowest major coordinate
    coord_t      minor;      // constant minor coordinate
    int unsigned count;
  } line_row_t;

  typedef struct {
    coord_t col;
    coord_t row;
    logic   last;
  } pixel_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data  = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  line_row_t   line_plan[$];
  pixel_t      pending_pixels[$];
  int unsigned next_idx       = 0;
  int unsigned cur_idx        = 0;
  int unsigned lines_accepted = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  logic        hold_active    = 1'b0;
  logic        hold_done      = 1'b0;
  int unsigned hold_left      = 0;

  wire calm = (cycle_count >= CalmFrom) && (cycle_count < CalmTo);

  line_pixel_rasterizer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void add_line(input coord_t sc, sr, ec, er, input bit typed = 1'b0,
                                   input bit col_major = 1'b0, input coord_t first = '0,
                                   input coord_t minor = '0, input int unsigned count = 0);
    line_row_t r;
    r.sc = sc; r.sr = sr; r.ec = ec; r.er = er;
    r.typed = typed; r.col_major = col_major;
    r.first = first; r.minor = minor; r.count = count;
    line_plan.push_back(r);
  endfunction

  // Queue the pixels of one line: major axis by larger distance, walk upwards, skip the far end
  function automatic void rasterize_line(input coord_t sc, sr, ec, er);
    coord_t      dc, dr, ms, me, ns, ne, t;
    bit          col_major;
    int unsigned span, minor;
    pixel_t      px;
    dc = (sc > ec) ? sc - ec : ec - sc;
    dr = (sr > er) ? sr - er : er - sr;
    col_major = dc > dr;
    if (col_major) begin
      ms = sc; me = ec; ns = sr; ne = er;
    end else begin
      ms = sr; me = er; ns = sc; ne = ec;
    end
    if (me < ms) begin
      t = ms; ms = me; me = t;
      t = ns; ns = ne; ne = t;
    end
    span = 32'(me - ms);
    for (int unsigned i = 0; i < span; i++) begin
      minor = (ns * (span - i) + ne * i + span / 2) / span;
      if (col_major) begin
        px.col = coord_t'(ms + i);
        px.row = coord_t'(minor);
      end else begin
        px.col = coord_t'(minor);
        px.row = coord_t'(ms + i);
      end
      px.last = (i + 1 == span);
      pending_pixels.push_back(px);
    end
  endfunction

  function automatic void expect_line(input line_row_t r);
    pixel_t px;
    if (!r.typed) begin
      rasterize_line(r.sc, r.sr, r.ec, r.er);
    end else begin
      for (int unsigned i = 0; i < r.count; i++) begin
        px.col  = r.col_major ? coord_t'(r.first + i) : r.minor;
        px.row  = r.col_major ? r.minor : coord_t'(r.first + i);
        px.last = (i + 1 == r.count);
        pending_pixels.push_back(px);
      end
    end
  endfunction

  function automatic void check_pixel(input coord_t col, row, input logic last);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports)
        $display("unexpected pixel col=%0d row=%0d last=%0b", col, row, last);
      return;
    end
    want = pending_pixels.pop_front();
    if (col !== want.col || row !== want.row || last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports)
        $display("pixel mismatch: expected col=%0d row=%0d last=%0b, got col=%0d row=%0d last=%0b",
                 want.col, want.row, want.last, col, row, last);
    end
  endfunction

  // Sender: hold each request until taken, gap at random between requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready) begin
        expect_line(line_plan[cur_idx]);
        lines_accepted <= lines_accepted + 1;
      end
      if (!s_valid || s_axis_tready) begin
        if (next_idx < line_plan.size() &&
            (calm || hold_active || $urandom_range(99) >= IdlePercent)) begin
          s_valid <= 1'b1;
          s_data  <= {line_plan[next_idx].er, line_plan[next_idx].ec,
                      line_plan[next_idx].sr, line_plan[next_idx].sc};
          cur_idx  <= next_idx;
          next_idx <= next_idx + 1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check every accepted pixel, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_ready)
        check_pixel(m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tlast);
      m_ready <= !hold_active && (calm || $urandom_range(99) >= IdlePercent);
    end
  end

  // Long hold-off on the output so the block backs up into its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && !hold_active && lines_accepted >= HoldAfter) begin
        hold_active <= 1'b1;
        hold_left   <= HoldCycles;
      end else if (hold_active) begin
        if (hold_left == 0) begin
          hold_active <= 1'b0;
          hold_done   <= 1'b1;
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // Coincident endpoints at both corners and inside: no pixels
    add_line(4'd0, 4'd0, 4'd0, 4'd0, 1'b1, 1'b0, 4'd0, 4'd0, 0);
    add_line(4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 1'b0, 4'd0, 4'd0, 0);
    add_line(4'd9, 4'd6, 4'd9, 4'd6, 1'b1, 1'b0, 4'd0, 4'd0, 0);
    // Straight lines, full-length in both directions, and short ones
    add_line(4'd0, 4'd0, 4'd15, 4'd0, 1'b1, 1'b1, 4'd0, 4'd0, 15);
    add_line(4'd15, 4'd15, 4'd0, 4'd15, 1'b1, 1'b1, 4'd0, 4'd15, 15);
    add_line(4'd0, 4'd0, 4'd0, 4'd15, 1'b1, 1'b0, 4'd0, 4'd0, 15);
    add_line(4'd15, 4'd15, 4'd15, 4'd0, 1'b1, 1'b0, 4'd0, 4'd15, 15);
    add_line(4'd5, 4'd3, 4'd9, 4'd3, 1'b1, 1'b1, 4'd5, 4'd3, 4);
    add_line(4'd7, 4'd3, 4'd7, 4'd2, 1'b1, 1'b0, 4'd2, 4'd7, 1);
    add_line(4'd14, 4'd10, 4'd15, 4'd10, 1'b1, 1'b1, 4'd14, 4'd10, 1);
    // Equal distances: row axis major
    add_line(4'd0, 4'd0, 4'd15, 4'd15);
    add_line(4'd15, 4'd0, 4'd0, 4'd15);
    add_line(4'd3, 4'd3, 4'd5, 4'd5);
    add_line(4'd8, 4'd1, 4'd7, 4'd0);
    // Shallow and steep slopes, swapped and unswapped
    add_line(4'd0, 4'd0, 4'd15, 4'd1);
    add_line(4'd0, 4'd0, 4'd1, 4'd15);
    add_line(4'd15, 4'd14, 4'd0, 4'd15);
    add_line(4'd15, 4'd15, 4'd0, 4'd0);
    add_line(4'd2, 4'd9, 4'd12, 4'd4);
    add_line(4'd11, 4'd2, 4'd6, 4'd13);
    add_line(4'd1, 4'd15, 4'd15, 4'd8);
    for (int unsigned n = 0; n < RandomLines; n++) begin
      coord_t a, b, c, d;
      a = coord_t'($urandom_range(15)); b = coord_t'($urandom_range(15));
      c = coord_t'($urandom_range(15)); d = coord_t'($urandom_range(15));
      case ($urandom_range(9))
        0: add_line(a, b, a, b);
        1: add_line(a, b, c, b);
        2: add_line(a, b, a, d);
        3: add_line(a, b, coord_t'(a + c), coord_t'(b + c));
        default: add_line(a, b, c, d);
      endcase
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (next_idx < line_plan.size() || s_valid)
      @(posedge clk_i);
    while (pending_pixels.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/lpr_pkg.sv
design/lpr_ctrl.sv
design/lpr_dp.sv
design/line_pixel_rasterizer.sv
verif/tb_line_pixel_rasterizer.sv
